// ===== design/arpc_pkg.sv =====
// Shared types and codes for the ARP cache with aging.
package arpc_pkg;

    // Action codes carried in a request.
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // Status codes returned with each response.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_PRESENT   = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // Reset value of the aging register, in seconds.
    localparam logic [15:0] AGING_RESET = 16'd60;

    // Width of the entry count field in a response.
    localparam int unsigned COUNT_W = 5;

    // One request.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] ip_address;
        logic [47:0] mac_in;
        logic [31:0] now_seconds;
    } req_t;

    // One response.
    typedef struct packed {
        logic [1:0]         status;
        logic [47:0]        mac_out;
        logic               mac_unset;
        logic               expired;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    // One stored table entry.
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } entry_t;

endpackage

// ===== design/arpc_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module arpc_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 112,
    parameter int unsigned AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data for an enabled read appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/arpc_ctrl.sv =====
// Sequencer: scans the entry RAM for the key, then updates the table and builds the response.
module arpc_ctrl #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IW      = 4,
    parameter int unsigned CW      = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  arpc_pkg::req_t        in_data,
    input  logic [15:0]           aging,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output arpc_pkg::rsp_t        rsp_data,
    output logic                  rd_en,
    output logic [IW-1:0]         rd_addr,
    input  arpc_pkg::entry_t      rd_data,
    output logic                  wr_en,
    output logic [IW-1:0]         wr_addr,
    output arpc_pkg::entry_t      wr_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    arpc_pkg::req_t        req_reg;
    logic [CW-1:0]         addr_reg;
    logic                  pend_reg;
    logic [IW-1:0]         pend_idx_reg;
    logic                  hit_reg;
    logic [IW-1:0]         hit_idx_reg;
    logic [47:0]           hit_mac_reg;
    logic [31:0]           hit_stamp_reg;
    logic                  free_reg;
    logic [IW-1:0]         free_idx_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [CW+4:0]         cnt_ext;
    logic                  commit;
    logic                  do_set;
    logic                  do_clr;
    logic                  scan_done;
    logic                  pend_valid;
    logic [31:0]           age;

    assign in_ready  = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_UPDATE);
    assign commit    = rsp_valid && rsp_ready;

    // Read sweep: one address per cycle until every entry has been issued.
    assign rd_en     = (state_reg == ST_SCAN) && (addr_reg != CW'(ENTRIES));
    assign rd_addr   = addr_reg[IW-1:0];
    assign scan_done = (state_reg == ST_SCAN) && !rd_en && !pend_reg;

    // Entry returned by the RAM this cycle is only trusted when its valid bit is set.
    assign pend_valid = valid_reg[pend_idx_reg];

    // State sequencing.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Response and table update, decided once the sweep has finished.
    assign age = req_reg.now_seconds - hit_stamp_reg;

    always_comb
    begin
        rsp_data = '0;
        do_set   = 1'b0;
        do_clr   = 1'b0;
        unique case (req_reg.action)
            arpc_pkg::ACT_LOOKUP:
            begin
                if (hit_reg)
                begin
                    rsp_data.mac_out   = hit_mac_reg;
                    rsp_data.mac_unset = (hit_mac_reg == 48'd0);
                    rsp_data.expired   = (age > {16'd0, aging});
                end
                else
                begin
                    rsp_data.status = arpc_pkg::STAT_NOT_FOUND;
                end
            end
            arpc_pkg::ACT_ADD:
            begin
                if (hit_reg)
                begin
                    rsp_data.status = arpc_pkg::STAT_PRESENT;
                end
                else if (free_reg)
                begin
                    do_set = 1'b1;
                end
                else
                begin
                    rsp_data.status = arpc_pkg::STAT_FULL;
                end
            end
            arpc_pkg::ACT_DELETE:
            begin
                if (hit_reg)
                begin
                    do_clr = 1'b1;
                end
                else
                begin
                    rsp_data.status = arpc_pkg::STAT_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        rsp_data.entry_count = cnt_ext[arpc_pkg::COUNT_W-1:0];
    end

    // Count after this operation; the response shows its low bits.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_set)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_clr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    assign cnt_ext = {5'd0, cnt_next};

    // New entry goes into the lowest free slot found by the sweep.
    assign wr_en         = commit && do_set;
    assign wr_addr       = free_idx_reg;
    assign wr_data.ip    = req_reg.ip_address;
    assign wr_data.mac   = req_reg.mac_in;
    assign wr_data.stamp = req_reg.now_seconds;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
            begin
                addr_reg <= '0;
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    addr_reg <= addr_reg + CW'(1);
                end
                if (pend_reg && pend_valid && (rd_data.ip == req_reg.ip_address))
                begin
                    hit_reg <= 1'b1;
                end
                if (pend_reg && !pend_valid)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (commit)
            begin
                cnt_reg <= cnt_next;
                if (do_set)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                if (do_clr)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Request hold and sweep results.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (rd_en)
        begin
            pend_idx_reg <= rd_addr;
        end
        if (pend_reg && pend_valid && !hit_reg && (rd_data.ip == req_reg.ip_address))
        begin
            hit_idx_reg   <= pend_idx_reg;
            hit_mac_reg   <= rd_data.mac;
            hit_stamp_reg <= rd_data.stamp;
        end
        if (pend_reg && !pend_valid && !free_reg)
        begin
            free_idx_reg <= pend_idx_reg;
        end
    end

endmodule

// ===== design/arp_cache_with_aging_top.sv =====
// ARP cache with aging top level: aging register, entry RAM, sequencer, output register.
//
// Each request (lookup, add or delete by IPv4 address) is handled by a sweep of the entry RAM's
// single read port, one entry per cycle, followed by an update step. One request is worked on
// at a time. The sequencer is free again once the response has moved into the output register,
// and a new request can be taken only then. A finished response sits in the output register,
// so the next request is accepted while the response waits to be taken. Valid bits sit in
// flip-flops and clear at reset, so no clearing pass is needed. Add uses the lowest-numbered
// free slot and reports a full table when none is free. Aged entries are only flagged on
// lookup; removing them is up to the user.
module arp_cache_with_aging_top #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  arpc_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output arpc_pkg::rsp_t out_data,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned EW = $bits(arpc_pkg::entry_t);

    logic [15:0]      aging_reg;
    logic             out_valid_reg;
    arpc_pkg::rsp_t   out_data_reg;
    logic             rsp_valid;
    logic             rsp_ready;
    arpc_pkg::rsp_t   rsp_data;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    arpc_pkg::entry_t rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    arpc_pkg::entry_t wr_data;

    // Aging threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_reg <= arpc_pkg::AGING_RESET;
        end
        else if (cfg_we)
        begin
            aging_reg <= cfg_wdata;
        end
    end

    // Entry storage.
    arpc_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (EW),
        .AW    (IW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sweep and update sequencer.
    arpc_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .CW      (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .aging     (aging_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Output register: takes a new response when empty or being drained.
    assign rsp_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            out_data_reg <= rsp_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/arpc_checker.sv =====
// Port-level checks on the ARP cache top level, with the bind that attaches them.
module arpc_checker #(
    parameter int unsigned ENTRIES = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input arpc_pkg::rsp_t out_data
);

    // The block works on one request at a time, so it is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one was still in progress");

    // Any status other than success carries no MAC and no flags.
    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != arpc_pkg::STAT_OK)) |->
        ((out_data.mac_out == 48'd0) && !out_data.mac_unset && !out_data.expired))
        else $error("failed request returned non-zero entry fields");

    // An unset MAC flag only comes with a successful lookup of an all-zero MAC.
    a_unset_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.mac_unset) |->
        ((out_data.mac_out == 48'd0) && (out_data.status == arpc_pkg::STAT_OK)))
        else $error("unset MAC flag disagrees with the returned MAC");

    // The entry count never exceeds the table size when it fits the field.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((ENTRIES > 31) || (out_data.entry_count <= ENTRIES)))
        else $error("entry count above table size");

    // A response not taken stays on the output unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled response changed or vanished");

endmodule

bind arp_cache_with_aging_top arpc_checker #(
    .ENTRIES (ENTRIES)
) u_arpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
